@@ src/ipv4pg_pkg.sv @@
// shared types and constants for the ipv4 test packet generator
`timescale 1ns / 1ps

package ipv4pg_pkg;

    // request codes
    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE  = 2'd1;
    localparam logic [1:0] REQ_ID_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_SRC_ADDR = 8'd0;
    localparam logic [7:0] CFG_DST_ADDR = 8'd1;
    localparam logic [7:0] CFG_PROTOCOL = 8'd2;
    localparam logic [7:0] CFG_TTL      = 8'd3;

    localparam logic [7:0]  VER_IHL       = 8'h45;
    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD   = 16'd65515;
    localparam logic [7:0]  PROTOCOL_INIT = 8'd17;
    localparam logic [7:0]  TTL_INIT      = 8'd64;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_header;
        logic        last_byte;
        logic [31:0] packets_done;
    } out_item_t;

    // inputs of the checksum unit
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [15:0] total_len;
        logic [15:0] ident;
        logic        load;
    } csum_ctrl_t;

endpackage

@@ src/ipv4pg_csum.sv @@
// ipv4 header checksum unit, result held from the start transfer
`timescale 1ns / 1ps

module ipv4pg_csum
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ipv4pg_pkg::csum_ctrl_t  ctrl,
    output logic [15:0]             header_sum
);
    import ipv4pg_pkg::*;

    logic [15:0] header_sum_reg;
    logic [15:0] header_sum_next;
    logic [18:0] full_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // sum all header words, fold carries twice, complement
    always_comb
    begin
        full_sum        = {3'b000, VER_IHL, 8'h00}
                        + {3'b000, ctrl.total_len}
                        + {3'b000, ctrl.ident}
                        + {3'b000, ctrl.ttl, ctrl.protocol}
                        + {3'b000, ctrl.src_addr[31:16]}
                        + {3'b000, ctrl.src_addr[15:0]}
                        + {3'b000, ctrl.dst_addr[31:16]}
                        + {3'b000, ctrl.dst_addr[15:0]};
        fold1           = {1'b0, full_sum[15:0]} + {14'd0, full_sum[18:16]};
        fold2           = fold1[15:0] + {15'd0, fold1[16]};
        header_sum_next = ~fold2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sum_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                header_sum_reg <= header_sum_next;
            end
        end
    end

    assign header_sum = header_sum_reg;

endmodule

@@ src/ipv4_packet_generator_core.sv @@
// top level of the ipv4 test packet generator
`timescale 1ns / 1ps

// an advance transfer shows its byte on the output in the cycle after acceptance
// throughput: one request per cycle while a held output byte is taken; output register is refilled while being drained
// start and identification-clear requests give no output transfer
// checksum is formed at the start transfer and held for the whole packet
// reset: idle, identification and packet count zero, addresses 0, protocol 17, ttl 64

module ipv4_packet_generator_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ipv4pg_pkg::in_item_t   in_data,
    // byte channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output ipv4pg_pkg::out_item_t  out_data,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import ipv4pg_pkg::*;

    // configuration registers
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [7:0]  protocol_reg;
    logic [7:0]  ttl_reg;

    // packet state
    logic [15:0] next_ident_reg,   next_ident_next;
    logic [15:0] packet_ident_reg, packet_ident_next;
    logic [31:0] packet_total_reg, packet_total_next;
    logic        busy_reg,         busy_next;
    logic [15:0] byte_pos_reg,     byte_pos_next;
    logic [15:0] latched_len_reg,  latched_len_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg,  out_data_next;

    logic        in_fire;
    logic        start_fire;
    logic        emit;
    logic [15:0] total_len;
    logic [15:0] last_pos;
    logic [15:0] payload_pos;
    logic        is_header;
    logic        is_last;
    logic [7:0]  hdr_byte;
    logic [15:0] header_sum;
    logic [15:0] clamped_len;
    csum_ctrl_t  csum_ctrl;

    assign cfg_ready = 1'b1;

    // output register frees when empty or being taken this cycle
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign start_fire = in_fire && (in_data.req_type == REQ_START);
    assign emit       = in_fire && (in_data.req_type == REQ_ADVANCE) && busy_reg;

    assign total_len   = HDR_BYTES + latched_len_reg;
    assign last_pos    = total_len - 16'd1;
    assign payload_pos = byte_pos_reg - HDR_BYTES;
    assign is_header   = (byte_pos_reg < HDR_BYTES);
    assign is_last     = (byte_pos_reg >= last_pos);
    assign clamped_len = (in_data.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                                 : in_data.payload_length;

    // checksum of the new header, taken with the start transfer
    always_comb
    begin
        csum_ctrl.src_addr  = src_addr_reg;
        csum_ctrl.dst_addr  = dst_addr_reg;
        csum_ctrl.ttl       = ttl_reg;
        csum_ctrl.protocol  = protocol_reg;
        csum_ctrl.total_len = HDR_BYTES + clamped_len;
        csum_ctrl.ident     = next_ident_reg;
        csum_ctrl.load      = start_fire;
    end

    ipv4pg_csum u_csum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (csum_ctrl),
        .header_sum (header_sum)
    );

    // header byte select, most significant byte of every field first
    always_comb
    begin
        case (byte_pos_reg[4:0])
            5'd0:    hdr_byte = VER_IHL;
            5'd1:    hdr_byte = 8'h00;
            5'd2:    hdr_byte = total_len[15:8];
            5'd3:    hdr_byte = total_len[7:0];
            5'd4:    hdr_byte = packet_ident_reg[15:8];
            5'd5:    hdr_byte = packet_ident_reg[7:0];
            5'd6:    hdr_byte = 8'h00;
            5'd7:    hdr_byte = 8'h00;
            5'd8:    hdr_byte = ttl_reg;
            5'd9:    hdr_byte = protocol_reg;
            5'd10:   hdr_byte = header_sum[15:8];
            5'd11:   hdr_byte = header_sum[7:0];
            5'd12:   hdr_byte = src_addr_reg[31:24];
            5'd13:   hdr_byte = src_addr_reg[23:16];
            5'd14:   hdr_byte = src_addr_reg[15:8];
            5'd15:   hdr_byte = src_addr_reg[7:0];
            5'd16:   hdr_byte = dst_addr_reg[31:24];
            5'd17:   hdr_byte = dst_addr_reg[23:16];
            5'd18:   hdr_byte = dst_addr_reg[15:8];
            default: hdr_byte = dst_addr_reg[7:0];
        endcase
    end

    // request handling
    always_comb
    begin
        next_ident_next   = next_ident_reg;
        packet_ident_next = packet_ident_reg;
        packet_total_next = packet_total_reg;
        busy_next         = busy_reg;
        byte_pos_next     = byte_pos_reg;
        latched_len_next  = latched_len_reg;

        if (in_fire)
        begin
            case (in_data.req_type)
                REQ_START:
                begin
                    // a start abandons any packet in progress
                    latched_len_next  = clamped_len;
                    packet_ident_next = next_ident_reg;
                    next_ident_next   = next_ident_reg + 16'd1;
                    packet_total_next = packet_total_reg + 32'd1;
                    byte_pos_next     = '0;
                    busy_next         = 1'b1;
                end
                REQ_ID_CLEAR:
                begin
                    next_ident_next = '0;
                end
                REQ_ADVANCE:
                begin
                    if (busy_reg)
                    begin
                        if (is_last)
                        begin
                            busy_next     = 1'b0;
                            byte_pos_next = '0;
                        end
                        else
                        begin
                            byte_pos_next = byte_pos_reg + 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register: load on an emitted byte, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.out_byte     = is_header ? hdr_byte : payload_pos[7:0];
            out_data_next.in_header    = is_header;
            out_data_next.last_byte    = is_last;
            out_data_next.packets_done = packet_total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg     <= '0;
            dst_addr_reg     <= '0;
            protocol_reg     <= PROTOCOL_INIT;
            ttl_reg          <= TTL_INIT;
            next_ident_reg   <= '0;
            packet_ident_reg <= '0;
            packet_total_reg <= '0;
            busy_reg         <= 1'b0;
            byte_pos_reg     <= '0;
            latched_len_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SRC_ADDR: src_addr_reg <= cfg_data;
                    CFG_DST_ADDR: dst_addr_reg <= cfg_data;
                    CFG_PROTOCOL: protocol_reg <= cfg_data[7:0];
                    CFG_TTL:      ttl_reg      <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            next_ident_reg   <= next_ident_next;
            packet_ident_reg <= packet_ident_next;
            packet_total_reg <= packet_total_next;
            busy_reg         <= busy_next;
            byte_pos_reg     <= byte_pos_next;
            latched_len_reg  <= latched_len_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // byte payload register, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
